// ----- rtl/core/psem_pkg.sv -----
// Package for the priority semaphore wait list: request and response
// structs, operation and status codes, wait list command/status structs.
// No dependencies.
`default_nettype none

package psem_pkg;

  // Priority levels held by the wait bitmap (8 to 64)
  localparam int PrioLevels = 64;
  localparam int PrioW      = 6;
  localparam int RowW       = 3;
  localparam int ColW       = 3;
  localparam int RowCount   = 8;
  localparam int RowBits    = 8;
  localparam int CountW     = 16;

  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    OP_WAIT   = 2'd0,
    OP_SIGNAL = 2'd1,
    OP_CANCEL = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_WAITING   = 3'd1,
    ST_ISR       = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_SATURATED = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]       operation;
    logic [PrioW-1:0] task_priority;
    logic             in_isr;
  } psem_req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              woken_valid;
    logic [PrioW-1:0]  woken_priority;
    logic [CountW-1:0] token_count;
  } psem_rsp_t;

  // Update command to the wait list
  typedef struct packed {
    logic             add;
    logic             remove;
    logic             pop;
    logic [PrioW-1:0] prio;
  } wl_cmd_t;

  // Wait list status: any waiter, and the most urgent one
  typedef struct packed {
    logic             any;
    logic [PrioW-1:0] top_prio;
  } wl_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/priority_semaphore_wait_list.sv -----
// Top level of the priority semaphore: request register, operation decode,
// token counter and response register. Depends on psem_pkg, psem_wait_list.
`default_nettype none

//  Channel | Direction | Handshake                | Payload
//  --------+-----------+--------------------------+------------------------
//  request | in        | in_valid_i / in_ready_o  | in_req_i  (psem_req_t)
//  result  | out       | out_valid_o / out_ready_i| out_rsp_o (psem_rsp_t)
//  config  | in        | cfg_we_i (no wait)       | cfg_wdata_i (16 bit)
//
//  One request per cycle sustained while the result is taken; a request
//  passes the request register, then the result register.
//  The decode, bitmap update and two-level search sit between those two.
//  Reset clears the token count, the wait bitmap and both valid flags.
//  A stalled result holds the request register; in_ready_o falls only when
//  both registers are full and the result is not taken.

module priority_semaphore_wait_list (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output      logic                           in_ready_o,
  input  wire psem_pkg::psem_req_t            in_req_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_ready_i,
  output      psem_pkg::psem_rsp_t            out_rsp_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [psem_pkg::CountW-1:0]    cfg_wdata_i
);

  localparam logic [psem_pkg::PrioW:0] LevelsExt =
    (psem_pkg::PrioW + 1)'(psem_pkg::PrioLevels);
  localparam logic [psem_pkg::PrioW-1:0] PrioTop =
    psem_pkg::PrioW'(psem_pkg::PrioLevels - 1);

  logic                          req_valid_q;
  psem_pkg::psem_req_t           req_q;
  logic                          out_valid_q;
  psem_pkg::psem_rsp_t           rsp_q, rsp_d;
  logic [psem_pkg::CountW-1:0]   count_q, count_d;
  logic                          advance;
  logic [psem_pkg::PrioW-1:0]    prio_sat;
  psem_pkg::wl_cmd_t             wl_cmd;
  psem_pkg::wl_stat_t            wl_stat;
  psem_pkg::status_e             status;

  assign advance    = req_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !req_valid_q || advance;

  // Hold the request until it moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_req_i;
    end
  end

  // Clamp priorities beyond the configured levels
  assign prio_sat = ({1'b0, req_q.task_priority} >= LevelsExt) ? PrioTop
                                                               : req_q.task_priority;

  // Decode the operation against count and wait list
  always_comb begin
    wl_cmd      = '0;
    wl_cmd.prio = prio_sat;
    status      = psem_pkg::ST_DONE;
    count_d     = count_q;
    rsp_d       = '0;
    case (psem_pkg::op_e'(req_q.operation))
      psem_pkg::OP_WAIT: begin
        if (req_q.in_isr) begin
          status = psem_pkg::ST_ISR;
        end else if (count_q != '0) begin
          count_d = count_q - 1'b1;
        end else begin
          wl_cmd.add = advance;
          status     = psem_pkg::ST_WAITING;
        end
      end
      psem_pkg::OP_SIGNAL: begin
        if (wl_stat.any) begin
          wl_cmd.pop           = advance;
          rsp_d.woken_valid    = 1'b1;
          rsp_d.woken_priority = wl_stat.top_prio;
        end else if (count_q == psem_pkg::CountMax) begin
          status = psem_pkg::ST_SATURATED;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      psem_pkg::OP_CANCEL: begin
        wl_cmd.remove = advance;
        status        = psem_pkg::ST_REMOVED;
      end
      default: begin
      end
    endcase
    rsp_d.status      = status;
    rsp_d.token_count = count_d;
  end

  psem_wait_list u_wait_list (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (wl_cmd),
    .stat_o (wl_stat)
  );

  // Load the count from configuration, else advance it with each request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end else if (advance) begin
      count_q <= count_d;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (req_valid_q && out_valid_q && !out_ready_i))
    else $error("request side stalled without a stalled result");

  a_queued_waiter_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wl_cmd.add |=> wl_stat.any)
    else $error("queued waiter missing from the wait list");

  a_woken_is_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.woken_valid |-> out_rsp_o.status == psem_pkg::ST_DONE)
    else $error("woken task reported with a non-done status");

  a_no_woken_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.woken_valid |-> out_rsp_o.woken_priority == '0)
    else $error("woken priority set without a woken task");

  a_saturated_at_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == psem_pkg::ST_SATURATED
      |-> out_rsp_o.token_count == psem_pkg::CountMax)
    else $error("saturation reported below the maximum count");

endmodule

`default_nettype wire

// ----- rtl/core/psem_wait_list.sv -----
// Two-tier wait bitmap (group byte plus eight row bytes) with a
// two-level lowest-set-bit search. Depends on psem_pkg.
`default_nettype none

module psem_wait_list (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire psem_pkg::wl_cmd_t  cmd_i,
  output psem_pkg::wl_stat_t      stat_o
);

  localparam int Bits = psem_pkg::RowCount * psem_pkg::RowBits;

  logic [Bits-1:0]                 rows_q, rows_d;
  logic [psem_pkg::RowCount-1:0]   group_q, group_d;
  logic [psem_pkg::RowW-1:0]       top_row;
  logic [psem_pkg::ColW-1:0]       top_col;
  logic [psem_pkg::RowBits-1:0]    top_byte;
  logic [psem_pkg::PrioW-1:0]      top_prio;

  // Index of the lowest set bit of a byte, zero when none
  function automatic logic [2:0] lowest_bit(input logic [7:0] m);
    logic [2:0] idx;
    idx = '0;
    for (int i = 7; i >= 0; i--) begin
      if (m[i]) begin
        idx = 3'(i);
      end
    end
    return idx;
  endfunction

  // Search the group first, then the chosen row
  always_comb begin
    top_row  = lowest_bit(group_q);
    top_byte = rows_q[top_row*psem_pkg::RowBits +: psem_pkg::RowBits];
    top_col  = lowest_bit(top_byte);
    top_prio = {top_row, top_col};
  end

  assign stat_o.any      = |group_q;
  assign stat_o.top_prio = top_prio;

  // Set, drop or pop one waiter; group bits follow the row contents
  always_comb begin
    rows_d = rows_q;
    if (cmd_i.add) begin
      rows_d[cmd_i.prio] = 1'b1;
    end
    if (cmd_i.remove) begin
      rows_d[cmd_i.prio] = 1'b0;
    end
    if (cmd_i.pop) begin
      rows_d[top_prio] = 1'b0;
    end
    for (int r = 0; r < psem_pkg::RowCount; r++) begin
      group_d[r] = |rows_d[r*psem_pkg::RowBits +: psem_pkg::RowBits];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= '0;
      group_q <= '0;
    end else begin
      rows_q  <= rows_d;
      group_q <= group_d;
    end
  end

  // Group bits mirror non-empty rows
  for (genvar g = 0; g < psem_pkg::RowCount; g++) begin : g_chk
    a_group_mirror: assert property (@(posedge clk_i) disable iff (!rst_ni)
      group_q[g] == (|rows_q[g*psem_pkg::RowBits +: psem_pkg::RowBits]))
      else $error("group bit out of step with its row");
  end

  a_pop_needs_waiter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> stat_o.any)
    else $error("pop issued with an empty wait list");

endmodule

`default_nettype wire

// ----- test/tb_priority_semaphore_wait_list.sv -----
// Testbench for priority_semaphore_wait_list: directed and random requests against a
// cycle-free prediction of token count and wait bitmap, checked per result.
// Depends on psem_pkg and the priority_semaphore_wait_list RTL.
`timescale 1ns / 100ps

module tb_priority_semaphore_wait_list;
  import psem_pkg::*;

  localparam int        ResultLatency = 2;
  localparam int        LongHold      = 64;
  localparam int        QuietLimit    = 1000;
  localparam int        PhaseItems    = 110;
  localparam logic [1:0] OpUnused     = 2'd3;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  psem_req_t           in_req_i    = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  psem_rsp_t           out_rsp_o;
  logic                cfg_we_i    = 1'b0;
  logic [CountW-1:0]   cfg_wdata_i = '0;

  // Predicted semaphore state
  logic [CountW-1:0]   token_level = '0;
  logic [RowCount-1:0] waiter_groups = '0;
  logic [RowBits-1:0]  waiter_rows [RowCount];

  psem_req_t           pending_req_q [$];
  psem_rsp_t           expected_rsp_q [$];

  int                  mismatch_count = 0;
  int                  idle_odds      = 0;
  int                  send_gap       = 0;
  int                  recv_gap       = 0;
  int                  recv_hold      = 0;
  int                  hold_asks      = 0;
  int                  holds_served   = 0;
  int                  quiet_cycles   = 0;

  priority_semaphore_wait_list dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int unsigned lowest_set(logic [7:0] mask);
    for (int i = 0; i < 8; i++) begin
      if (mask[i]) return i;
    end
    return 0;
  endfunction

  // Drop one waiter; release its group bit once the row is empty
  function automatic void clear_waiter(int unsigned row, int unsigned col);
    waiter_rows[row][col] = 1'b0;
    if (waiter_rows[row] == '0) waiter_groups[row] = 1'b0;
  endfunction

  // Apply one request to the predicted state and return the expected result
  function automatic psem_rsp_t step_semaphore(psem_req_t req);
    psem_rsp_t   rsp;
    int unsigned prio;
    int unsigned row;
    int unsigned col;
    rsp  = '0;
    prio = req.task_priority;
    if (prio >= PrioLevels) prio = PrioLevels - 1;
    row = prio >> RowW;
    col = prio % RowBits;
    case (req.operation)
      OP_WAIT: begin
        if (req.in_isr) begin
          rsp.status = ST_ISR;
        end else if (token_level != '0) begin
          token_level = token_level - 1'b1;
          rsp.status  = ST_DONE;
        end else begin
          waiter_rows[row][col] = 1'b1;
          waiter_groups[row]    = 1'b1;
          rsp.status            = ST_WAITING;
        end
      end
      OP_SIGNAL: begin
        if (waiter_groups != '0) begin
          row                = lowest_set(waiter_groups);
          col                = lowest_set(waiter_rows[row]);
          rsp.woken_valid    = 1'b1;
          rsp.woken_priority = PrioW'(row * RowBits + col);
          clear_waiter(row, col);
          rsp.status         = ST_DONE;
        end else if (token_level == CountMax) begin
          rsp.status = ST_SATURATED;
        end else begin
          token_level = token_level + 1'b1;
          rsp.status  = ST_DONE;
        end
      end
      OP_CANCEL: begin
        clear_waiter(row, col);
        rsp.status = ST_REMOVED;
      end
      default: begin
        rsp.status = ST_DONE;
      end
    endcase
    rsp.token_count = token_level;
    return rsp;
  endfunction

  function automatic psem_req_t make_req(logic [1:0] op, int prio, bit isr);
    psem_req_t req;
    req.operation     = op;
    req.task_priority = prio[PrioW-1:0];
    req.in_isr        = isr;
    return req;
  endfunction

  function automatic psem_req_t random_req();
    int         pick;
    logic [1:0] op;
    pick = $urandom_range(99, 0);
    if (pick < 40)      op = OP_WAIT;
    else if (pick < 75) op = OP_SIGNAL;
    else if (pick < 95) op = OP_CANCEL;
    else                op = OpUnused;
    return make_req(op, $urandom_range(PrioLevels - 1, 0), $urandom_range(99, 0) < 8);
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Load the token count; only called with the block idle
  task automatic load_count(logic [CountW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    token_level  = value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  // Hold until every request is taken and every result checked
  task automatic drain_and_settle();
    do @(negedge clk_i);
    while (pending_req_q.size() != 0 || in_valid_i || expected_rsp_q.size() != 0);
    repeat (ResultLatency + 1) @(negedge clk_i);
  endtask

  task automatic random_phase(logic [CountW-1:0] value, int odds, bit long_stall);
    load_count(value);
    idle_odds = odds;
    repeat (PhaseItems) pending_req_q.push_back(random_req());
    if (long_stall) hold_asks++;
    drain_and_settle();
  endtask

  // Sender: advance to the next request once the current one is taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) expected_rsp_q.push_back(step_semaphore(in_req_i));
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0) begin
          send_gap = $urandom_range(12, 0);
          in_valid_i <= 1'b0;
        end else if (pending_req_q.size() != 0) begin
          in_req_i   <= pending_req_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result, then decide on stalling
  always @(posedge clk_i) begin
    psem_rsp_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("unexpected result, token_count", out_rsp_o.token_count, 0);
        end else begin
          want = expected_rsp_q.pop_front();
          if (out_rsp_o.status != want.status)
            report_mismatch("status", out_rsp_o.status, want.status);
          if (out_rsp_o.woken_valid != want.woken_valid)
            report_mismatch("woken_valid", out_rsp_o.woken_valid, want.woken_valid);
          if (out_rsp_o.woken_priority != want.woken_priority)
            report_mismatch("woken_priority", out_rsp_o.woken_priority, want.woken_priority);
          if (out_rsp_o.token_count != want.token_count)
            report_mismatch("token_count", out_rsp_o.token_count, want.token_count);
        end
      end
      if (holds_served != hold_asks) begin
        holds_served = hold_asks;
        recv_hold    = LongHold;
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_ready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0) begin
        recv_gap = $urandom_range(12, 0);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == QuietLimit) begin
        $display("tb_priority_semaphore_wait_list: FAIL");
        $finish;
      end
    end
  end

  initial begin
    for (int r = 0; r < RowCount; r++) waiter_rows[r] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: fill the wait list at count zero, then drain it by priority
    idle_odds = 6;
    pending_req_q.push_back(make_req(OP_WAIT, 0, 1'b0));
    pending_req_q.push_back(make_req(OP_WAIT, 63, 1'b0));
    pending_req_q.push_back(make_req(OP_WAIT, 7, 1'b0));
    pending_req_q.push_back(make_req(OP_WAIT, 8, 1'b0));
    pending_req_q.push_back(make_req(OP_WAIT, 35, 1'b0));
    pending_req_q.push_back(make_req(OP_WAIT, 63, 1'b0));    // already waiting
    pending_req_q.push_back(make_req(OP_WAIT, 20, 1'b1));    // interrupt context
    pending_req_q.push_back(make_req(OP_CANCEL, 20, 1'b0));  // not waiting
    pending_req_q.push_back(make_req(OP_CANCEL, 35, 1'b1));
    pending_req_q.push_back(make_req(OP_SIGNAL, 0, 1'b0));
    pending_req_q.push_back(make_req(OP_SIGNAL, 5, 1'b1));
    pending_req_q.push_back(make_req(OP_SIGNAL, 63, 1'b0));
    pending_req_q.push_back(make_req(OP_SIGNAL, 0, 1'b0));
    pending_req_q.push_back(make_req(OP_SIGNAL, 0, 1'b0));   // no waiter left
    pending_req_q.push_back(make_req(OP_WAIT, 42, 1'b0));
    pending_req_q.push_back(make_req(OpUnused, 63, 1'b1));
    pending_req_q.push_back(make_req(OpUnused, 0, 1'b0));
    drain_and_settle();

    // Directed: count at its ceiling
    load_count(CountMax);
    pending_req_q.push_back(make_req(OP_SIGNAL, 0, 1'b0));
    pending_req_q.push_back(make_req(OP_WAIT, 12, 1'b1));
    pending_req_q.push_back(make_req(OP_WAIT, 1, 1'b0));
    pending_req_q.push_back(make_req(OP_SIGNAL, 33, 1'b1));
    pending_req_q.push_back(make_req(OP_SIGNAL, 0, 1'b0));
    pending_req_q.push_back(make_req(OP_CANCEL, 63, 1'b0));
    drain_and_settle();

    // Random phases; low counts keep the wait list busy
    random_phase('0, 8, 1'b0);
    random_phase(16'd1, 3, 1'b1);
    random_phase(16'd3, 20, 1'b0);
    random_phase(CountMax, 8, 1'b0);
    random_phase(CountMax - 1'b1, 4, 1'b0);
    random_phase(CountW'($urandom_range(15, 0)), 8, 1'b0);
    random_phase(CountW'($urandom_range(65535, 0)), 12, 1'b0);
    random_phase('0, 0, 1'b0);

    if (mismatch_count == 0) begin
      $display("tb_priority_semaphore_wait_list: PASS");
    end else begin
      $display("tb_priority_semaphore_wait_list: FAIL");
    end
    $finish;
  end

endmodule
